>>> rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths shared by the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int CoordW   = 16;
  localparam int EdgeW    = CoordW + 1;
  localparam int ProdW    = 2 * EdgeW;
  localparam int CrossW   = ProdW + 1;
  localparam int MagW     = CrossW;
  localparam int SumW     = 2 * MagW + 2;
  localparam int RootW    = SumW / 2;
  localparam int SqRemW   = RootW + 2;
  localparam int DivRemW  = RootW + 1;
  localparam int FracBits = 14;
  localparam int QuotW    = FracBits + 1;
  localparam int NormW    = 16;

  localparam logic [QuotW-1:0] QuotMax = QuotW'(1) << FracBits;

endpackage

`default_nettype wire

>>> rtl/triangle_face_normal.sv
// Triangle face normal: one request per cycle, busy_o never rises.
// Its pipeline holds a 36-stage square root and a 15-stage divider,
// one bit per stage. The receiver cannot stall. Reset clears all stage
// valid bits.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Cross product of two triangle edges, normalized to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal (
  input  wire  logic                        clk_i,
  input  wire  logic                        rst_ni,
  input  wire  logic                        start_i,
  output logic                              busy_o,
  input  wire  logic [tfn_pkg::CoordW-1:0]  ax_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  ay_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  az_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  bx_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  by_coord_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  bz_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  cx_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  cy_i,
  input  wire  logic [tfn_pkg::CoordW-1:0]  cz_i,
  input  wire  logic                        last_in_i,
  output logic                              valid_o,
  output logic [tfn_pkg::NormW-1:0]         nx_o,
  output logic [tfn_pkg::NormW-1:0]         ny_o,
  output logic [tfn_pkg::NormW-1:0]         nz_o,
  output logic                              degenerate_o,
  output logic                              last_out_o
);
  import tfn_pkg::*;

  assign busy_o = 1'b0;

  // Edges
  logic                    v1_q, l1_q;
  logic signed [EdgeW-1:0] e0_q [3];
  logic signed [EdgeW-1:0] e1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    l1_q    <= last_in_i;
    e0_q[0] <= EdgeW'($signed(bx_i)) - EdgeW'($signed(ax_i));
    e0_q[1] <= EdgeW'($signed(by_coord_i)) - EdgeW'($signed(ay_i));
    e0_q[2] <= EdgeW'($signed(bz_i)) - EdgeW'($signed(az_i));
    e1_q[0] <= EdgeW'($signed(cx_i)) - EdgeW'($signed(ax_i));
    e1_q[1] <= EdgeW'($signed(cy_i)) - EdgeW'($signed(ay_i));
    e1_q[2] <= EdgeW'($signed(cz_i)) - EdgeW'($signed(az_i));
  end

  // Products
  logic                    v2_q, l2_q;
  logic signed [ProdW-1:0] p_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    l2_q   <= l1_q;
    p_q[0] <= ProdW'(e0_q[1]) * ProdW'(e1_q[2]);
    p_q[1] <= ProdW'(e0_q[2]) * ProdW'(e1_q[1]);
    p_q[2] <= ProdW'(e0_q[2]) * ProdW'(e1_q[0]);
    p_q[3] <= ProdW'(e0_q[0]) * ProdW'(e1_q[2]);
    p_q[4] <= ProdW'(e0_q[0]) * ProdW'(e1_q[1]);
    p_q[5] <= ProdW'(e0_q[1]) * ProdW'(e1_q[0]);
  end

  // Cross terms as sign and magnitude
  logic                     v3_q, l3_q;
  logic [MagW-1:0]          m3_q [3];
  logic                     n3_q [3];
  logic signed [CrossW-1:0] x_d  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_d[i] = CrossW'(p_q[2*i]) - CrossW'(p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    l3_q <= l2_q;
    for (int i = 0; i < 3; i++) begin
      n3_q[i] <= x_d[i][CrossW-1];
      m3_q[i] <= x_d[i][CrossW-1] ? MagW'(-x_d[i]) : MagW'(x_d[i]);
    end
  end

  // Squares
  logic            v4_q, l4_q;
  logic [MagW-1:0] m4_q [3];
  logic            n4_q [3];
  logic [SumW-1:0] sq4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    l4_q <= l3_q;
    for (int i = 0; i < 3; i++) begin
      m4_q[i]  <= m3_q[i];
      n4_q[i]  <= n3_q[i];
      sq4_q[i] <= SumW'(m3_q[i]) * SumW'(m3_q[i]);
    end
  end

  // Sum of squares
  logic            v5_q, l5_q;
  logic [MagW-1:0] m5_q [3];
  logic            n5_q [3];
  logic [SumW-1:0] s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    l5_q <= l4_q;
    m5_q <= m4_q;
    n5_q <= n4_q;
    s5_q <= sq4_q[0] + sq4_q[1] + sq4_q[2];
  end

  // Square root, one result bit per stage
  logic              sv_q  [RootW];
  logic              sl_q  [RootW];
  logic [SumW-1:0]   rad_q [RootW];
  logic [RootW-1:0]  rt_q  [RootW];
  logic [SqRemW-1:0] rm_q  [RootW];
  logic [MagW-1:0]   sm_q  [RootW][3];
  logic              sn_q  [RootW][3];

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic              v_in, l_in;
    logic [SumW-1:0]   rad_in;
    logic [RootW-1:0]  rt_in;
    logic [SqRemW-1:0] rm_in, rm2, trial;
    logic [MagW-1:0]   m_in [3];
    logic              n_in [3];

    if (k == 0) begin : g_first
      assign v_in   = v5_q;
      assign l_in   = l5_q;
      assign rad_in = s5_q;
      assign rt_in  = '0;
      assign rm_in  = '0;
      assign m_in   = m5_q;
      assign n_in   = n5_q;
    end else begin : g_next
      assign v_in   = sv_q[k-1];
      assign l_in   = sl_q[k-1];
      assign rad_in = rad_q[k-1];
      assign rt_in  = rt_q[k-1];
      assign rm_in  = rm_q[k-1];
      assign m_in   = sm_q[k-1];
      assign n_in   = sn_q[k-1];
    end

    assign rm2   = {rm_in[SqRemW-3:0], rad_in[SumW-1 -: 2]};
    assign trial = {rt_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k] <= 1'b0;
      else         sv_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      sl_q[k]  <= l_in;
      sm_q[k]  <= m_in;
      sn_q[k]  <= n_in;
      rad_q[k] <= {rad_in[SumW-3:0], 2'b00};
      if (rm2 >= trial) begin
        rm_q[k] <= rm2 - trial;
        rt_q[k] <= {rt_in[RootW-2:0], 1'b1};
      end else begin
        rm_q[k] <= rm2;
        rt_q[k] <= {rt_in[RootW-2:0], 1'b0};
      end
    end
  end

  // Division of each magnitude by the root, one quotient bit per stage
  logic               dv_q  [QuotW];
  logic               dl_q  [QuotW];
  logic [RootW-1:0]   drt_q [QuotW];
  logic [DivRemW-1:0] dr_q  [QuotW][3];
  logic [QuotW-1:0]   dq_q  [QuotW][3];
  logic               dn_q  [QuotW][3];

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    logic               v_in, l_in;
    logic [RootW-1:0]   rt_in;
    logic [DivRemW-1:0] r_in [3];
    logic [DivRemW-1:0] r2   [3];
    logic [QuotW-1:0]   q_in [3];
    logic               n_in [3];

    if (k == 0) begin : g_first
      assign v_in  = sv_q[RootW-1];
      assign l_in  = sl_q[RootW-1];
      assign rt_in = rt_q[RootW-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign r_in[j] = DivRemW'(sm_q[RootW-1][j] >> 1);
        assign r2[j]   = {r_in[j][DivRemW-2:0], sm_q[RootW-1][j][0]};
        assign q_in[j] = '0;
        assign n_in[j] = sn_q[RootW-1][j];
      end
    end else begin : g_next
      assign v_in  = dv_q[k-1];
      assign l_in  = dl_q[k-1];
      assign rt_in = drt_q[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign r_in[j] = dr_q[k-1][j];
        assign r2[j]   = {r_in[j][DivRemW-2:0], 1'b0};
        assign q_in[j] = dq_q[k-1][j];
        assign n_in[j] = dn_q[k-1][j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else         dv_q[k] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      dl_q[k]  <= l_in;
      drt_q[k] <= rt_in;
      for (int j = 0; j < 3; j++) begin
        dn_q[k][j] <= n_in[j];
        if (r2[j] >= DivRemW'(rt_in)) begin
          dr_q[k][j] <= r2[j] - DivRemW'(rt_in);
          dq_q[k][j] <= {q_in[j][QuotW-2:0], 1'b1};
        end else begin
          dr_q[k][j] <= r2[j];
          dq_q[k][j] <= {q_in[j][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  // Clamp, sign and output register
  logic             deg_d;
  logic [QuotW-1:0] qc_d [3];
  logic [NormW-1:0] n_d  [3];
  logic             valid_q, deg_q, last_q;
  logic [NormW-1:0] n_q  [3];

  always_comb begin
    deg_d = (drt_q[QuotW-1] == '0);
    for (int j = 0; j < 3; j++) begin
      qc_d[j] = (dq_q[QuotW-1][j] > QuotMax) ? QuotMax : dq_q[QuotW-1][j];
      if (deg_d)                  n_d[j] = '0;
      else if (dn_q[QuotW-1][j])  n_d[j] = NormW'(-NormW'(qc_d[j]));
      else                        n_d[j] = NormW'(qc_d[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= dv_q[QuotW-1];
  end

  always_ff @(posedge clk_i) begin
    deg_q  <= deg_d;
    last_q <= dl_q[QuotW-1];
    n_q    <= n_d;
  end

  assign valid_o      = valid_q;
  assign nx_o         = n_q[0];
  assign ny_o         = n_q[1];
  assign nz_o         = n_q[2];
  assign degenerate_o = deg_q;
  assign last_out_o   = last_q;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Triangle face normal testbench
// Sends directed triangles, then random triangles with random start gaps,
// predicts each unit normal from the corner coordinates and checks every result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  typedef logic signed [tfn_pkg::CoordW-1:0] coord_t;

  typedef struct packed {
    logic [tfn_pkg::NormW-1:0] nx;
    logic [tfn_pkg::NormW-1:0] ny;
    logic [tfn_pkg::NormW-1:0] nz;
    logic                      degenerate;
    logic                      last;
  } normal_t;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  coord_t ax_i = '0, ay_i = '0, az_i = '0;
  coord_t bx_i = '0, by_coord_i = '0, bz_i = '0;
  coord_t cx_i = '0, cy_i = '0, cz_i = '0;
  logic last_in_i = 1'b0;
  logic valid_o;
  logic [tfn_pkg::NormW-1:0] nx_o, ny_o, nz_o;
  logic degenerate_o, last_out_o;

  normal_t expected_normals[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  always #2 clk_i = ~clk_i;

  triangle_face_normal u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .ax_i, .ay_i, .az_i, .bx_i, .by_coord_i, .bz_i, .cx_i, .cy_i, .cz_i,
    .last_in_i, .valid_o, .nx_o, .ny_o, .nz_o, .degenerate_o, .last_out_o
  );

  function automatic logic [tfn_pkg::NormW-1:0] scale_component(
      longint w, logic [63:0] root);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (w < 0) ? 64'(-w) : 64'(w);
    q = (mag << tfn_pkg::FracBits) / root;
    if (q > (64'd1 << tfn_pkg::FracBits)) q = 64'd1 << tfn_pkg::FracBits;
    if (w < 0) q = -q;
    return q[tfn_pkg::NormW-1:0];
  endfunction

  function automatic normal_t face_normal(coord_t a[3], coord_t b[3], coord_t c[3],
      logic last);
    longint e0[3], e1[3], w[3];
    logic [95:0] sum, sq, root, trial;
    normal_t n;
    for (int k = 0; k < 3; k++) begin
      e0[k] = longint'(b[k]) - longint'(a[k]);
      e1[k] = longint'(c[k]) - longint'(a[k]);
    end
    w[0] = e0[1] * e1[2] - e0[2] * e1[1];
    w[1] = e0[2] * e1[0] - e0[0] * e1[2];
    w[2] = e0[0] * e1[1] - e0[1] * e1[0];
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sq = 96'(w[k] < 0 ? -w[k] : w[k]);
      sum += sq * sq;
    end
    n = '0;
    n.last = last;
    if (sum == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    root = '0;
    for (int bitpos = 39; bitpos >= 0; bitpos--) begin
      trial = root | (96'd1 << bitpos);
      if (trial * trial <= sum) root = trial;
    end
    n.nx = scale_component(w[0], root[63:0]);
    n.ny = scale_component(w[1], root[63:0]);
    n.nz = scale_component(w[2], root[63:0]);
    return n;
  endfunction

  task automatic send_face(coord_t a[3], coord_t b[3], coord_t c[3], logic last,
      int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    {ax_i, ay_i, az_i} = {a[0], a[1], a[2]};
    {bx_i, by_coord_i, bz_i} = {b[0], b[1], b[2]};
    {cx_i, cy_i, cz_i} = {c[0], c[1], c[2]};
    last_in_i = last;
    start_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    expected_normals = {expected_normals, face_normal(a, b, c, last)};
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  task automatic test_directed();
    coord_t lo, hi, a[3], b[3], c[3];
    lo = -16'sd32768;
    hi = 16'sd32767;
    a = '{0, 0, 0}; b = '{0, 0, 0}; c = '{0, 0, 0};
    send_face(a, b, c, 1'b0, 0);
    b = '{1, 0, 0}; c = '{0, 1, 0};
    send_face(a, b, c, 1'b1, 0);
    b = '{0, 1, 0}; c = '{0, 0, 1};
    send_face(a, b, c, 1'b0, 0);
    b = '{0, 0, 1}; c = '{1, 0, 0};
    send_face(a, b, c, 1'b1, 1);
    b = '{0, 1, 0}; c = '{1, 0, 0};
    send_face(a, b, c, 1'b0, 0);
    a = '{lo, lo, lo}; b = '{hi, lo, lo}; c = '{lo, hi, lo};
    send_face(a, b, c, 1'b0, 0);
    a = '{hi, hi, hi}; b = '{lo, hi, hi}; c = '{hi, hi, lo};
    send_face(a, b, c, 1'b1, 2);
    a = '{lo, hi, lo}; b = '{hi, lo, hi}; c = '{lo, lo, hi};
    send_face(a, b, c, 1'b0, 0);
    a = '{hi, lo, hi}; b = '{lo, hi, lo}; c = '{hi, hi, lo};
    send_face(a, b, c, 1'b0, 0);
    a = '{lo, lo, lo}; b = '{hi, hi, hi}; c = '{hi, lo, hi};
    send_face(a, b, c, 1'b1, 0);
    a = '{lo, lo, lo}; b = '{hi, hi, hi}; c = '{0, 0, 0};
    send_face(a, b, c, 1'b0, 0);
    a = '{5, 5, 5}; b = '{5, 5, 5}; c = '{hi, lo, 7};
    send_face(a, b, c, 1'b0, 3);
    a = '{-3, 2, 9}; b = '{-1, 6, 12}; c = '{1, 10, 15};
    send_face(a, b, c, 1'b1, 0);
    a = '{lo, lo, lo}; b = '{lo, lo, lo}; c = '{lo, lo, lo};
    send_face(a, b, c, 1'b1, 0);
    a = '{hi, hi, hi}; b = '{hi, hi, hi}; c = '{hi, hi, hi};
    send_face(a, b, c, 1'b0, 0);
    a = '{-1, -1, -1}; b = '{hi, -1, -1}; c = '{-1, -1, hi};
    send_face(a, b, c, 1'b0, 0);
    a = '{0, 0, 0}; b = '{1, 1, 0}; c = '{hi, lo, 1};
    send_face(a, b, c, 1'b1, 0);
  endtask

  task automatic test_random(int count);
    coord_t a[3], b[3], c[3];
    int kind, gap, span, mult;
    bit burst;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_coord();
        b[k] = rand_coord();
        c[k] = rand_coord();
      end
      if (kind < 3) begin
        span = $urandom_range(1, 200);
        for (int k = 0; k < 3; k++) begin
          b[k] = coord_t'(int'(a[k]) + $urandom_range(0, 2 * span) - span);
          c[k] = coord_t'(int'(a[k]) + $urandom_range(0, 2 * span) - span);
        end
      end else if (kind == 3) begin
        mult = $urandom_range(0, 4) - 2;
        for (int k = 0; k < 3; k++) begin
          a[k] = coord_t'($urandom_range(0, 2000) - 1000);
          b[k] = coord_t'(int'(a[k]) + $urandom_range(0, 200) - 100);
          c[k] = coord_t'(int'(a[k]) + mult * (int'(b[k]) - int'(a[k])));
        end
      end
      gap = burst ? 0 : $urandom_range(0, 14);
      send_face(a, b, c, 1'($urandom), gap);
    end
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    normal_t exp_n;
    if (rst_ni && valid_o) begin
      if (expected_normals.size() == 0) begin
        $error("result strobe with no request pending");
        errors++;
      end else begin
        exp_n = expected_normals.pop_front();
        if (nx_o !== exp_n.nx) begin
          $error("nx: expected %0d, actual %0d", $signed(exp_n.nx), $signed(nx_o));
          errors++;
        end
        if (ny_o !== exp_n.ny) begin
          $error("ny: expected %0d, actual %0d", $signed(exp_n.ny), $signed(ny_o));
          errors++;
        end
        if (nz_o !== exp_n.nz) begin
          $error("nz: expected %0d, actual %0d", $signed(exp_n.nz), $signed(nz_o));
          errors++;
        end
        if (degenerate_o !== exp_n.degenerate) begin
          $error("degenerate: expected %0b, actual %0b", exp_n.degenerate, degenerate_o);
          errors++;
        end
        if (last_out_o !== exp_n.last) begin
          $error("last_out: expected %0b, actual %0b", exp_n.last, last_out_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(1830);
    wait (expected_normals.size() == 0);
    repeat (70) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
